/* hw/rtl/lcmc_pkg.sv */
// ----------------------------------------------------------------------------
// lcmc_pkg: shared definitions for the LRU cache miss counter
// Register map constants, port widths and the control bundle that the
// top level sends to every cell of the recency stack.
// ----------------------------------------------------------------------------
package lcmc_pkg;

	// Width of the key and count ports.
	localparam int unsigned PORT_W = 32;

	// Width of the capacity register.
	localparam int unsigned CAP_W = 5;

	// APB address width and register offsets.
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

	// Per-transaction controls broadcast to all cells.
	typedef struct packed {
		logic lookup;   // compare the incoming key against the stored entry
		logic update;   // shift the stack according to the limit index
	} cell_ctrl_t;

endpackage

/* hw/rtl/lru_cache_miss_counter.sv */
// ----------------------------------------------------------------------------
// lru_cache_miss_counter: fully associative cache with LRU replacement
// A chain of key cells forms the recency stack; the top level sequences
// lookups and shifts and keeps the occupancy and the miss count.
// ----------------------------------------------------------------------------
// A request is accepted when start is high and busy is low. Every cell
// compares its key with the request in the accept cycle, and in the next
// cycle the stack shifts down by one cell from the top to the hit position
// or the fill limit; busy stays high through the shift, so no new request
// is accepted until it is done. The result is driven on hit, evicted,
// evicted_key and miss_count for exactly one cycle with done high, in the
// cycle in which busy drops; it must be taken in that cycle. Keys are compared
// on their low KEY_WIDTH bits. Write capacity over the APB port only while no
// request is in flight.
// ----------------------------------------------------------------------------
module lru_cache_miss_counter #(
	parameter int unsigned MAX_ENTRIES = 16,
	parameter int unsigned KEY_WIDTH   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel.
	input  logic                                start,
	output logic                                busy,
	input  logic [lcmc_pkg::PORT_W-1:0]         key,
	input  logic                                first,
	// Result channel.
	output logic                                done,
	output logic                                hit,
	output logic                                evicted,
	output logic [lcmc_pkg::PORT_W-1:0]         evicted_key,
	output logic [lcmc_pkg::PORT_W-1:0]         miss_count,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lcmc_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned CW    = (CNT_W > lcmc_pkg::CAP_W) ? CNT_W : lcmc_pkg::CAP_W;
	localparam int unsigned PW    = lcmc_pkg::PORT_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic                        state_q;
	logic [lcmc_pkg::CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]            occ_q;
	logic [PW-1:0]               miss_q;
	logic [KEY_WIDTH-1:0]        key_q;
	logic                        done_q;
	logic                        hit_q;
	logic                        evicted_q;
	logic [PW-1:0]               evicted_key_q;

	logic                        accept;
	logic [KEY_WIDTH-1:0]        key_in;
	logic [CNT_W-1:0]            occ_limit;
	lcmc_pkg::cell_ctrl_t        ctrl;
	logic [KEY_WIDTH-1:0]        entry [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0]        taps  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]      match_vec;
	logic                        any_hit;
	logic [CNT_W-1:0]            hit_pos;
	logic [CW-1:0]               cap_eff;
	logic                        full;
	logic [CNT_W-1:0]            shift_lim;
	logic [CNT_W-1:0]            vic_idx;
	logic [KEY_WIDTH-1:0]        victim;
	logic [PW-1:0]               victim_out;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q == ST_UPD);
	assign pready = 1'b1;

	// Request key reduced or extended to the internal key width.
	if (KEY_WIDTH <= PW) begin : g_key_narrow
		assign key_in     = key[KEY_WIDTH-1:0];
		assign victim_out = PW'(victim);
	end else begin : g_key_wide
		assign key_in     = {{(KEY_WIDTH-PW){1'b0}}, key};
		assign victim_out = victim[PW-1:0];
	end

	// A first request sees an empty stack during lookup.
	assign occ_limit   = first ? '0 : occ_q;
	assign ctrl.lookup = accept;
	assign ctrl.update = (state_q == ST_UPD);

	// Capacity register and readback.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lcmc_pkg::CAP_W'(16);
		end else if (psel && penable && pwrite && (paddr == lcmc_pkg::ADDR_CAPACITY)) begin
			cap_q <= pwdata[lcmc_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr == lcmc_pkg::ADDR_CAPACITY) ? 32'(cap_q) : '0;

	// Effective capacity: zero reads as one, and it is bounded by the depth.
	always_comb begin
		cap_eff = CW'(cap_q);
		if (cap_eff == '0) begin
			cap_eff = CW'(1);
		end
		if (cap_eff > CW'(MAX_ENTRIES)) begin
			cap_eff = CW'(MAX_ENTRIES);
		end
	end

	// Hit position from the one-hot match vector.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_pos = hit_pos | CNT_W'(i);
			end
		end
	end

	assign any_hit   = |match_vec;
	assign full      = (CW'(occ_q) >= cap_eff);
	assign vic_idx   = occ_q - CNT_W'(1);
	assign shift_lim = any_hit ? hit_pos : (full ? vic_idx : occ_q);

	// Chain of stack cells; the top cell takes the request key.
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [KEY_WIDTH-1:0] prev;
		if (g == 0) begin : g_top
			assign prev = key_q;
		end else begin : g_rest
			assign prev = entry[g-1];
		end
		lcmc_cell #(
			.INDEX     (g),
			.KEY_WIDTH (KEY_WIDTH),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.req_key   (key_in),
			.occ_limit (occ_limit),
			.shift_lim (shift_lim),
			.vic_idx   (vic_idx),
			.prev_key  (prev),
			.entry     (entry[g]),
			.match     (match_vec[g]),
			.tap       (taps[g])
		);
	end

	// Bottom entry, picked by OR-ing the cell taps.
	always_comb begin
		victim = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			victim = victim | taps[i];
		end
	end

	// Sequencer, occupancy and miss count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			miss_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPD);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_UPD;
						if (first) begin
							occ_q  <= '0;
							miss_q <= '0;
						end
					end
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					if (!any_hit) begin
						if (miss_q != '1) begin
							miss_q <= miss_q + PW'(1);
						end
						if (!full) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request key held for the shift cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_in;
		end
	end

	// Result registers, loaded in the shift cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			hit_q         <= any_hit;
			evicted_q     <= !any_hit && full;
			evicted_key_q <= (!any_hit && full) ? victim_out : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign miss_count  = miss_q;

	// Every shift cycle follows an accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $past(start && !busy))
		else $error("shift cycle without an accepted request");

	// A result is strobed only right after a shift cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a shift cycle");

	// At most one occupied entry matches any key.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $onehot0(match_vec))
		else $error("duplicate keys in the recency stack");

	// Occupancy never exceeds the built depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(MAX_ENTRIES))
		else $error("occupancy above depth");

	// A hit never evicts, and an eviction comes with a counted miss.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> !hit && (miss_count != '0))
		else $error("eviction reported on a hit");

endmodule

/* hw/rtl/lcmc_cell.sv */
// ----------------------------------------------------------------------------
// lcmc_cell: one entry of the recency stack
// Holds one key, compares it with a request, and on update takes the key
// of its upper neighbor when it lies at or above the shift limit.
// ----------------------------------------------------------------------------
module lcmc_cell #(
	parameter int unsigned INDEX     = 0,
	parameter int unsigned KEY_WIDTH = 32,
	parameter int unsigned CNT_W     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcmc_pkg::cell_ctrl_t  ctrl,
	input  logic [KEY_WIDTH-1:0]  req_key,
	input  logic [CNT_W-1:0]      occ_limit,
	input  logic [CNT_W-1:0]      shift_lim,
	input  logic [CNT_W-1:0]      vic_idx,
	input  logic [KEY_WIDTH-1:0]  prev_key,
	output logic [KEY_WIDTH-1:0]  entry,
	output logic                  match,
	output logic [KEY_WIDTH-1:0]  tap
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [KEY_WIDTH-1:0] entry_q;
	logic                 match_q;

	// Match flag, captured when the request is accepted. Only occupied
	// entries take part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.lookup) begin
			match_q <= (req_key == entry_q) && (MY_IDX < occ_limit);
		end
	end

	// Stored key: shift down from the neighbor when inside the moved range.
	always_ff @(posedge clk) begin
		if (ctrl.update && (MY_IDX <= shift_lim)) begin
			entry_q <= prev_key;
		end
	end

	assign entry = entry_q;
	assign match = match_q;
	assign tap   = (MY_IDX == vic_idx) ? entry_q : '0;

endmodule
